FILE: hw/rtl/b64e_pkg.sv
package b64e_pkg;

    // Register indexes on the config port
    localparam logic [1:0] CFG_CHAR_62 = 2'd0;
    localparam logic [1:0] CFG_CHAR_63 = 2'd1;
    localparam logic [1:0] CFG_PAD     = 2'd2;

    localparam logic [7:0] RST_CHAR_62 = 8'd43;  // '+'
    localparam logic [7:0] RST_CHAR_63 = 8'd47;  // '/'
    localparam logic [7:0] RST_PAD     = 8'd61;  // '='

    // Up to four output characters per input byte
    localparam int MAX_TOK = 4;

    // Position within the current three-byte group
    typedef enum logic [2:0] {
        PH_0 = 3'b001,
        PH_1 = 3'b010,
        PH_2 = 3'b100
    } t_phase;

    // One output character before mapping: a sextet or a pad
    typedef struct packed {
        logic       pad;
        logic [5:0] sext;
    } t_tok;

    // Everything one input byte produces
    typedef struct packed {
        t_tok [MAX_TOK-1:0] toks;
        logic [1:0]         last_idx;
        logic               msg_end;
    } t_entry;

    // Standard alphabet for 0..61, config characters for 62 and 63
    function automatic logic [7:0] sext_to_char(
        input logic [5:0] v,
        input logic [7:0] c62,
        input logic [7:0] c63
    );
        logic [7:0] ch;
        begin
            if (v == 6'd62) begin
                ch = c62;
            end else if (v == 6'd63) begin
                ch = c63;
            end else if (v < 6'd26) begin
                ch = 8'd65 + {2'b00, v};
            end else if (v < 6'd52) begin
                ch = 8'd71 + {2'b00, v};        // 'a' - 26
            end else begin
                ch = {2'b00, v} - 8'd4;         // '0' - 52
            end
            return ch;
        end
    endfunction

endpackage

FILE: hw/rtl/b64e_front.sv
// Splits each byte into sextets and pads, tracks group phase and leftover bits
module b64e_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_byte,
    input  logic                i_final,
    output b64e_pkg::t_entry    o_entry
);

    b64e_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_held, n_held;
    b64e_pkg::t_entry w_entry;

    localparam b64e_pkg::t_tok TOK_PAD = '{pad: 1'b1, sext: 6'd0};

    // Classify the byte against the current phase
    always_comb begin
        w_entry          = '0;
        w_entry.msg_end  = i_final;
        n_phase          = r_phase;
        n_held           = r_held;
        case (r_phase)
            b64e_pkg::PH_1: begin
                w_entry.toks[0] = '{pad: 1'b0, sext: {r_held[1:0], i_byte[7:4]}};
                w_entry.toks[1] = '{pad: 1'b0, sext: {i_byte[3:0], 2'b00}};
                w_entry.toks[2] = TOK_PAD;
                w_entry.last_idx = i_final ? 2'd2 : 2'd0;
                n_phase = b64e_pkg::PH_2;
                n_held  = i_byte[3:0];
            end
            b64e_pkg::PH_2: begin
                w_entry.toks[0] = '{pad: 1'b0, sext: {r_held, i_byte[7:6]}};
                w_entry.toks[1] = '{pad: 1'b0, sext: i_byte[5:0]};
                w_entry.last_idx = 2'd1;
                n_phase = b64e_pkg::PH_0;
                n_held  = 4'd0;
            end
            default: begin
                w_entry.toks[0] = '{pad: 1'b0, sext: i_byte[7:2]};
                w_entry.toks[1] = '{pad: 1'b0, sext: {i_byte[1:0], 4'b0000}};
                w_entry.toks[2] = TOK_PAD;
                w_entry.toks[3] = TOK_PAD;
                w_entry.last_idx = i_final ? 2'd3 : 2'd0;
                n_phase = b64e_pkg::PH_1;
                n_held  = {2'b00, i_byte[1:0]};
            end
        endcase
        // Final byte starts a new message
        if (i_final) begin
            n_phase = b64e_pkg::PH_0;
            n_held  = 4'd0;
        end
    end

    assign o_entry = w_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= b64e_pkg::PH_0;
            r_held  <= 4'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

FILE: hw/rtl/b64e_queue.sv
// Small queue of classified entries between front and back
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64e_pkg::t_entry    i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output b64e_pkg::t_entry    o_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    b64e_pkg::t_entry r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/b64e_back.sv
// Walks entries one character per unstalled cycle to the output reg
module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  b64e_pkg::t_entry    i_q_entry,
    output logic                o_q_pop,
    input  logic [7:0]          i_char_62,
    input  logic [7:0]          i_char_63,
    input  logic [7:0]          i_pad_char,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_char,
    output logic                o_run_last,
    output logic                o_msg_end
);

    b64e_pkg::t_entry r_ent;
    logic             r_busy;
    logic [1:0]       r_idx;
    logic             r_ovalid;
    logic [7:0]       r_ochar;
    logic             r_olast;
    logic             r_oend;

    logic             w_adv, w_at_last, w_load;
    b64e_pkg::t_tok   w_tok;
    logic [7:0]       w_char;

    assign w_adv     = !r_ovalid || i_ready;
    assign w_at_last = (r_idx == r_ent.last_idx);
    assign w_load    = !r_busy || (w_adv && w_at_last);
    assign o_q_pop   = w_load && !i_q_empty;

    // Map current token to a character
    assign w_tok  = r_ent.toks[r_idx];
    assign w_char = w_tok.pad ? i_pad_char
                              : b64e_pkg::sext_to_char(w_tok.sext, i_char_62, i_char_63);

    // Current entry and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (w_load) begin
            r_busy <= !i_q_empty;
            r_idx  <= 2'd0;
        end else if (w_adv) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_ent <= i_q_entry;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_ovalid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_ochar <= w_char;
            r_olast <= w_at_last;
            r_oend  <= w_at_last && r_ent.msg_end;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_char     = r_ochar;
    assign o_run_last = r_olast;
    assign o_msg_end  = r_oend;

endmodule

FILE: hw/rtl/base64_stream_encoder_top.sv
// An input beat passes the entry queue, entry register and output register to the
// output. One character per cycle while the receiver is ready; a byte yields 1, 2
// or (when final) 3-4 characters, so the single output port bounds the byte rate.
// Input is taken every cycle while the entry queue has room.
// Reset (i_rst_n low, synchronous) empties the queue and output, returns the group
// phase to the start and sets the characters to '+', '/' and '='.
module base64_stream_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // is_final
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] text_char
    output logic        m_axis_tuser,   // [0] run_last
    output logic        m_axis_tlast,   // message_end
    // config writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0]       r_char_62, r_char_63, r_pad;
    b64e_pkg::t_entry w_front_entry, w_q_entry;
    logic             w_q_full, w_q_empty, w_q_pop, w_in_acc;

    // Config registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_62 <= b64e_pkg::RST_CHAR_62;
            r_char_63 <= b64e_pkg::RST_CHAR_63;
            r_pad     <= b64e_pkg::RST_PAD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                b64e_pkg::CFG_CHAR_62: r_char_62 <= i_cfg_data;
                b64e_pkg::CFG_CHAR_63: r_char_63 <= i_cfg_data;
                b64e_pkg::CFG_PAD:     r_pad     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = !w_q_full;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_acc),
        .i_byte   (s_axis_tdata),
        .i_final  (s_axis_tlast),
        .o_entry  (w_front_entry)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_acc),
        .i_entry (w_front_entry),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_entry (w_q_entry)
    );

    b64e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_entry  (w_q_entry),
        .o_q_pop    (w_q_pop),
        .i_char_62  (r_char_62),
        .i_char_63  (r_char_63),
        .i_pad_char (r_pad),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_char     (m_axis_tdata),
        .o_run_last (m_axis_tuser),
        .o_msg_end  (m_axis_tlast)
    );

endmodule

FILE: hw/rtl/b64e_checker.sv
// Port-level checks for the encoder
module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast,
    input logic       o_cfg_ready
);

    // Output is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // Message end is always the last character of its byte
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("message end without run last");

    // Stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // Config writes never stall
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .o_cfg_ready   (o_cfg_ready)
);

FILE: test/tb_base64_stream_encoder_top.sv
module tb_base64_stream_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_GAP      = 10;
    localparam int LONG_HOLD    = 80;     // receiver hold-off, long enough to back up the input
    localparam int DRAIN_CYCLES = 12;     // settle time after the last character
    localparam int IDLE_LIMIT   = 2000;   // cycles without any beat before giving up
    localparam int CHUNK_ITEMS  = 38;     // random bytes per config setting
    localparam int DIR_ROWS     = 26;

    // Index beyond the register map, writes to it are dropped
    localparam logic [1:0] CFG_NONE = 2'd3;

    // One encoded character as it leaves the block
    typedef struct packed {
        logic [7:0] text_char;
        logic       run_last;
        logic       message_end;
    } t_b64_char;

    // Directed stimulus: byte beats and register writes
    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    // For beats, n_typed > 0 gives the characters written out in typed (first char leftmost)
    typedef struct packed {
        t_row_kind  kind;
        logic [1:0] index;
        logic [7:0] value;
        logic       fin;
        logic [2:0] n_typed;
        logic [31:0] typed;
    } t_dir_row;

    t_dir_row dir_rows [DIR_ROWS] = '{
        // default characters, read straight off the alphabet
        '{ROW_BEAT, '0, 8'h00, 1'b1, 3'd4, "AA=="},
        '{ROW_BEAT, '0, 8'hFF, 1'b1, 3'd4, "/w=="},
        '{ROW_BEAT, '0, 8'h4D, 1'b0, 3'd1, "T"},
        '{ROW_BEAT, '0, 8'h61, 1'b0, 3'd1, "W"},
        '{ROW_BEAT, '0, 8'h6E, 1'b1, 3'd2, "Fu"},
        '{ROW_BEAT, '0, 8'h4D, 1'b0, 3'd1, "T"},
        '{ROW_BEAT, '0, 8'h61, 1'b1, 3'd3, "WE="},
        '{ROW_BEAT, '0, 8'hFB, 1'b0, 3'd1, "+"},
        '{ROW_BEAT, '0, 8'hFF, 1'b0, 3'd1, "/"},
        '{ROW_BEAT, '0, 8'hBF, 1'b0, 3'd2, "+/"},
        '{ROW_BEAT, '0, 8'h80, 1'b1, 3'd4, "gA=="},
        // remapped 62/63, NUL pad, plus a write to an unmapped index
        '{ROW_CFG,  b64e_pkg::CFG_CHAR_62, 8'h2D, 1'b0, 3'd0, '0},
        '{ROW_CFG,  b64e_pkg::CFG_CHAR_63, 8'h5F, 1'b0, 3'd0, '0},
        '{ROW_CFG,  b64e_pkg::CFG_PAD,     8'h00, 1'b0, 3'd0, '0},
        '{ROW_CFG,  CFG_NONE,              8'hAA, 1'b0, 3'd0, '0},
        '{ROW_BEAT, '0, 8'hFB, 1'b0, 3'd0, '0},
        '{ROW_BEAT, '0, 8'hFF, 1'b1, 3'd0, '0},
        '{ROW_BEAT, '0, 8'hFF, 1'b1, 3'd0, '0},
        '{ROW_BEAT, '0, 8'h3F, 1'b0, 3'd0, '0},
        '{ROW_CFG,  b64e_pkg::CFG_CHAR_62, 8'hFF, 1'b0, 3'd0, '0},
        '{ROW_CFG,  b64e_pkg::CFG_CHAR_63, 8'h00, 1'b0, 3'd0, '0},
        '{ROW_CFG,  b64e_pkg::CFG_PAD,     8'hFF, 1'b0, 3'd0, '0},
        '{ROW_BEAT, '0, 8'hFF, 1'b0, 3'd0, '0},
        '{ROW_BEAT, '0, 8'hFF, 1'b0, 3'd0, '0},
        '{ROW_BEAT, '0, 8'hFF, 1'b1, 3'd0, '0},
        '{ROW_BEAT, '0, 8'h00, 1'b1, 3'd0, '0}
    };

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index   = '0;
    logic [7:0] i_cfg_data    = '0;

    // Typed characters travel with the beat they belong to
    int          pin_count = 0;
    logic [31:0] pin_text  = '0;

    // Encoder mirror: characters, group position, leftover bits
    logic [7:0]       cfg_c62   = b64e_pkg::RST_CHAR_62;
    logic [7:0]       cfg_c63   = b64e_pkg::RST_CHAR_63;
    logic [7:0]       cfg_pad   = b64e_pkg::RST_PAD;
    b64e_pkg::t_phase grp_phase = b64e_pkg::PH_0;
    logic [3:0]       held_bits = '0;

    t_b64_char pending_chars [$];
    int        err_count    = 0;
    int        idle_cycles  = 0;

    // Idling controls
    logic gapless_tx    = 1'b0;
    logic gapless_rx    = 1'b0;
    int   hold_requests = 0;
    int   holds_served  = 0;

    base64_stream_encoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] data_byte
        .s_axis_tlast  (s_axis_tlast),    // is_final
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] text_char
        .m_axis_tuser  (m_axis_tuser),    // [0] run_last
        .m_axis_tlast  (m_axis_tlast),    // message_end
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Sextet to ASCII under the current 62/63 characters
    function automatic logic [7:0] sextet_ascii(input logic [5:0] v);
        if (v < 6'd26)
            return 8'("A") + 8'(v);
        else if (v < 6'd52)
            return 8'("a") + 8'(v - 6'd26);
        else if (v < 6'd62)
            return 8'("0") + 8'(v - 6'd52);
        else if (v == 6'd62)
            return cfg_c62;
        return cfg_c63;
    endfunction

    // Characters one byte yields; advances the group position
    function automatic int encode_byte(input logic [7:0] d, input logic fin,
                                       output logic [3:0][7:0] chars);
        int n;
        chars = '0;
        case (grp_phase)
            b64e_pkg::PH_1: begin
                chars[0] = sextet_ascii({held_bits[1:0], d[7:4]});
                n = 1;
                if (fin) begin
                    chars[1] = sextet_ascii({d[3:0], 2'b00});
                    chars[2] = cfg_pad;
                    n = 3;
                end
                held_bits = d[3:0];
                grp_phase = b64e_pkg::PH_2;
            end
            b64e_pkg::PH_2: begin
                chars[0] = sextet_ascii({held_bits, d[7:6]});
                chars[1] = sextet_ascii(d[5:0]);
                n = 2;
                held_bits = '0;
                grp_phase = b64e_pkg::PH_0;
            end
            default: begin
                chars[0] = sextet_ascii(d[7:2]);
                n = 1;
                if (fin) begin
                    chars[1] = sextet_ascii({d[1:0], 4'b0000});
                    chars[2] = cfg_pad;
                    chars[3] = cfg_pad;
                    n = 4;
                end
                held_bits = {2'b00, d[1:0]};
                grp_phase = b64e_pkg::PH_1;
            end
        endcase
        // a final byte always closes the message
        if (fin) begin
            grp_phase = b64e_pkg::PH_0;
            held_bits = '0;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Beat monitor: checks characters, queues what each accepted byte should yield
    always @(posedge i_clk) begin : check_beats
        logic [3:0][7:0] chars;
        int              n;
        t_b64_char       want;
        t_b64_char       next_char;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch("unexpected character", m_axis_tdata, 0);
                end else begin
                    want = pending_chars.pop_front();
                    if (m_axis_tdata !== want.text_char)
                        report_mismatch("text_char", m_axis_tdata, want.text_char);
                    if (m_axis_tuser !== want.run_last)
                        report_mismatch("run_last", m_axis_tuser, want.run_last);
                    if (m_axis_tlast !== want.message_end)
                        report_mismatch("message_end", m_axis_tlast, want.message_end);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n = encode_byte(s_axis_tdata, s_axis_tlast, chars);
                if (pin_count != 0) begin
                    n = pin_count;
                    for (int k = 0; k < n; k++)
                        chars[k] = pin_text[8 * (n - 1 - k) +: 8];
                end
                for (int k = 0; k < n; k++) begin
                    next_char = '{chars[k], k == n - 1, s_axis_tlast && k == n - 1};
                    pending_chars.insert(pending_chars.size(), next_char);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    b64e_pkg::CFG_CHAR_62: cfg_c62 = i_cfg_data;
                    b64e_pkg::CFG_CHAR_63: cfg_c63 = i_cfg_data;
                    b64e_pkg::CFG_PAD:     cfg_pad = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_base64_stream_encoder_top failed");
                $finish;
            end
        end
    end

    // Character sink: random stalls, one long hold-off on request
    initial begin : char_sink
        int stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = gapless_rx ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_requests != holds_served) begin
                holds_served++;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // Offer one byte after a random gap (none when gapless_tx is set); tvalid stays high on return
    task automatic send_byte(input logic [7:0] d, input logic fin,
                             input int n_typed, input logic [31:0] typed);
        int gap;
        gap = gapless_tx ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= d;
        s_axis_tlast  <= fin;
        pin_count     <= n_typed;
        pin_text      <= typed;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Stop offering and wait until every queued character has come out
    task automatic finish_stream();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        i_cfg_index <= index;
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Main sequence
    initial begin : stimulus
        int left;
        int len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                finish_stream();
                write_reg(dir_rows[r].index, dir_rows[r].value);
            end else begin
                send_byte(dir_rows[r].value, dir_rows[r].fin, dir_rows[r].n_typed,
                          dir_rows[r].typed);
            end
        end

        // random messages under four character settings
        for (int chunk = 0; chunk < 4; chunk++) begin
            finish_stream();
            gapless_tx = 1'b0;
            gapless_rx = 1'b0;
            case (chunk)
                0: begin
                    write_reg(b64e_pkg::CFG_CHAR_62, 8'($urandom_range(0, 255)));
                    write_reg(b64e_pkg::CFG_CHAR_63, 8'($urandom_range(0, 255)));
                    write_reg(b64e_pkg::CFG_PAD, 8'($urandom_range(0, 255)));
                    write_reg(CFG_NONE, 8'($urandom_range(0, 255)));
                end
                1: begin
                    write_reg(b64e_pkg::CFG_CHAR_62, 8'h00);
                    write_reg(b64e_pkg::CFG_CHAR_63, 8'h00);
                    write_reg(b64e_pkg::CFG_PAD, 8'h00);
                    gapless_tx = 1'b1;
                    gapless_rx = 1'b1;
                end
                2: begin
                    write_reg(b64e_pkg::CFG_CHAR_62, 8'hFF);
                    write_reg(b64e_pkg::CFG_CHAR_63, 8'hFF);
                    write_reg(b64e_pkg::CFG_PAD, 8'hFF);
                    // sink holds off while bytes keep coming back to back
                    hold_requests++;
                    gapless_tx = 1'b1;
                end
                default: begin
                    write_reg(b64e_pkg::CFG_CHAR_62, b64e_pkg::RST_CHAR_62);
                    write_reg(b64e_pkg::CFG_CHAR_63, b64e_pkg::RST_CHAR_63);
                    write_reg(b64e_pkg::CFG_PAD, b64e_pkg::RST_PAD);
                end
            endcase
            left = CHUNK_ITEMS;
            while (left > 0) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(1, 9);
                if (len > left)
                    len = left;
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)), i == len - 1, 0, '0);
                left -= len;
            end
        end

        finish_stream();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_chars.size() == 0)
            $display("tb_base64_stream_encoder_top passed");
        else
            $display("tb_base64_stream_encoder_top failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder_top.sv
hw/rtl/b64e_checker.sv
test/tb_base64_stream_encoder_top.sv
